[rtl/core/i2c_master_byte_engine_assert.svh]
// Assertion macros for the I2C master byte engine.
`ifndef I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_ASSERT_SVH

`ifndef ASSERT_OFF
`define I2CM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define I2CM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define I2CM_ASSERT(lbl, clk, rstn, prop, msg)
`define I2CM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[rtl/core/i2cm_pkg.sv]
package i2cm_pkg;

    localparam int unsigned HALF_W     = 8;
    localparam int unsigned ADDR_W     = 7;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned OP_W       = 3;
    localparam int unsigned STEP_W     = 5;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [HALF_W-1:0] DEFAULT_HALF_PERIOD = 8'd10;

    localparam logic [STEP_W-1:0] SEG_START_CNT = 5'd3;
    localparam logic [STEP_W-1:0] SEG_STOP_CNT  = 5'd2;
    localparam logic [STEP_W-1:0] SEG_BYTE_CNT  = 5'd27;
    localparam logic [STEP_W-1:0] SEG_ACK_DATA  = 5'd24;
    localparam logic [STEP_W-1:0] SEG_ACK_HIGH  = 5'd25;

    typedef enum logic [OP_W-1:0] {
        OP_NONE   = 3'd0,
        OP_START  = 3'd1,
        OP_STOP   = 3'd2,
        OP_WRITE  = 3'd3,
        OP_READ   = 3'd4,
        OP_ADDR_W = 3'd5,
        OP_ADDR_R = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        CMD_IDLE,
        CMD_START,
        CMD_STOP,
        CMD_WRITE,
        CMD_READ
    } t_cmd;

    typedef enum logic [1:0] {
        PH_DATA,
        PH_HIGH,
        PH_LOW
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HALF_PERIOD = 1'b0,
        CFG_DEVICE_ADDR = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [BYTE_W-1:0] tx_byte;
        logic              send_ack;
        logic              sda_in;
    } t_in_word;

    typedef struct packed {
        logic              scl_drive;
        logic              sda_drive;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] rx_byte;
        logic              ack_received;
    } t_res;

    function automatic logic [STEP_W-1:0] seg_count(input t_cmd cmd);
        logic [STEP_W-1:0] cnt;
        case (cmd)
            CMD_START: cnt = SEG_START_CNT;
            CMD_STOP:  cnt = SEG_STOP_CNT;
            default:   cnt = SEG_BYTE_CNT;
        endcase
        return cnt;
    endfunction

endpackage

[rtl/core/i2cm_cmd_if.sv]
interface i2cm_cmd_if import i2cm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] tx_byte;
    logic              send_ack;
    logic              sda_in;

    modport source (output valid, output operation, output tx_byte, output send_ack,
                    output sda_in, input ready);
    modport sink   (input valid, input operation, input tx_byte, input send_ack,
                    input sda_in, output ready);
endinterface

[rtl/core/i2cm_res_if.sv]
interface i2cm_res_if import i2cm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              scl_drive;
    logic              sda_drive;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;
    logic              ack_received;

    modport source (output valid, output scl_drive, output sda_drive, output busy_res,
                    output done_res, output rx_byte, output ack_received, input ready);
    modport sink   (input valid, input scl_drive, input sda_drive, input busy_res,
                    input done_res, input rx_byte, input ack_received, output ready);
endinterface

[rtl/core/i2cm_seq.sv]
module i2cm_seq import i2cm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_acc,
    input  t_in_word              i_word,
    output t_res                  o_res
);

    t_cmd              r_cmd,         n_cmd;
    logic [STEP_W-1:0] r_step,        n_step;
    t_phase            r_phase,       n_phase;
    logic [HALF_W-1:0] r_tick,        n_tick;
    logic [BYTE_W-1:0] r_tx,          n_tx;
    logic [BYTE_W-1:0] r_rx,          n_rx;
    logic              r_ack,         n_ack;
    logic              r_answer_ack,  n_answer_ack;
    logic              r_scl,         n_scl;
    logic              r_sda,         n_sda;
    logic [HALF_W-1:0] r_half_period;
    logic [ADDR_W-1:0] r_dev_addr;
    logic [HALF_W-1:0] half_period;
    logic              done;

    assign half_period = (r_half_period == '0) ? DEFAULT_HALF_PERIOD : r_half_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= '0;
            r_dev_addr    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HALF_PERIOD: r_half_period <= i_cfg_data;
                CFG_DEVICE_ADDR: r_dev_addr    <= i_cfg_data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd        <= CMD_IDLE;
            r_step       <= '0;
            r_phase      <= PH_DATA;
            r_tick       <= '0;
            r_tx         <= '0;
            r_rx         <= '0;
            r_ack        <= 1'b0;
            r_answer_ack <= 1'b0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
        end else begin
            r_cmd        <= n_cmd;
            r_step       <= n_step;
            r_phase      <= n_phase;
            r_tick       <= n_tick;
            r_tx         <= n_tx;
            r_rx         <= n_rx;
            r_ack        <= n_ack;
            r_answer_ack <= n_answer_ack;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
        end
    end

    always_comb begin
        logic              enter;
        logic [STEP_W-1:0] step_inc;
        n_cmd        = r_cmd;
        n_step       = r_step;
        n_phase      = r_phase;
        n_tick       = r_tick;
        n_tx         = r_tx;
        n_rx         = r_rx;
        n_ack        = r_ack;
        n_answer_ack = r_answer_ack;
        n_scl        = r_scl;
        n_sda        = r_sda;
        done         = 1'b0;
        enter        = 1'b0;
        step_inc     = r_step + 5'd1;

        if (i_acc) begin
            if (r_cmd == CMD_IDLE) begin
                case (i_word.operation)
                    OP_START: n_cmd = CMD_START;
                    OP_STOP:  n_cmd = CMD_STOP;
                    OP_WRITE: begin
                        n_cmd = CMD_WRITE;
                        n_tx  = i_word.tx_byte;
                    end
                    OP_READ: begin
                        n_cmd        = CMD_READ;
                        n_rx         = '0;
                        n_answer_ack = i_word.send_ack;
                    end
                    OP_ADDR_W: begin
                        n_cmd = CMD_WRITE;
                        n_tx  = {r_dev_addr, 1'b0};
                    end
                    OP_ADDR_R: begin
                        n_cmd = CMD_WRITE;
                        n_tx  = {r_dev_addr, 1'b1};
                    end
                    default: ;
                endcase
                if (n_cmd != CMD_IDLE) begin
                    n_step  = '0;
                    n_phase = PH_DATA;
                    n_tick  = 8'd1;
                    enter   = 1'b1;
                end
            end else if (r_tick < half_period) begin
                n_tick = r_tick + 8'd1;
            end else begin
                // sample at the end of the segment
                if (r_cmd == CMD_WRITE && r_step == SEG_ACK_HIGH) begin
                    n_ack = ~i_word.sda_in;
                end else if (r_cmd == CMD_READ && r_step < SEG_ACK_DATA
                             && r_phase == PH_HIGH) begin
                    n_rx = {r_rx[BYTE_W-2:0], i_word.sda_in};
                end
                if (step_inc == seg_count(r_cmd)) begin
                    if (r_cmd == CMD_READ) begin
                        n_sda = 1'b1;
                    end
                    n_cmd   = CMD_IDLE;
                    n_step  = '0;
                    n_phase = PH_DATA;
                    n_tick  = '0;
                    done    = 1'b1;
                end else begin
                    n_step = step_inc;
                    case (r_phase)
                        PH_DATA: n_phase = PH_HIGH;
                        PH_HIGH: n_phase = PH_LOW;
                        default: n_phase = PH_DATA;
                    endcase
                    n_tick = 8'd1;
                    enter  = 1'b1;
                end
            end
        end

        if (enter) begin
            case (n_cmd)
                CMD_START: begin
                    if (n_step == 5'd0) begin
                        n_sda = 1'b1;
                        n_scl = 1'b1;
                    end else if (n_step == 5'd1) begin
                        n_sda = 1'b0;
                    end else begin
                        n_scl = 1'b0;
                    end
                end
                CMD_STOP: begin
                    if (n_step == 5'd0) begin
                        n_sda = 1'b0;
                        n_scl = 1'b1;
                    end else begin
                        n_sda = 1'b1;
                    end
                end
                CMD_WRITE: begin
                    if (n_step < SEG_ACK_DATA) begin
                        case (n_phase)
                            PH_DATA: begin
                                n_sda = n_tx[BYTE_W-1];
                                n_tx  = {n_tx[BYTE_W-2:0], 1'b0};
                            end
                            PH_HIGH: n_scl = 1'b1;
                            default: n_scl = 1'b0;
                        endcase
                    end else if (n_step == SEG_ACK_DATA) begin
                        n_sda = 1'b1;
                    end else if (n_step == SEG_ACK_HIGH) begin
                        n_scl = 1'b1;
                    end else begin
                        n_scl = 1'b0;
                    end
                end
                CMD_READ: begin
                    if (n_step < SEG_ACK_DATA) begin
                        if (n_step == 5'd0) begin
                            n_sda = 1'b1;
                        end
                        case (n_phase)
                            PH_HIGH: n_scl = 1'b1;
                            PH_LOW:  n_scl = 1'b0;
                            default: ;
                        endcase
                    end else if (n_step == SEG_ACK_DATA) begin
                        n_sda = ~n_answer_ack;
                    end else if (n_step == SEG_ACK_HIGH) begin
                        n_scl = 1'b1;
                    end else begin
                        n_scl = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_res.scl_drive    = n_scl;
        o_res.sda_drive    = n_sda;
        o_res.busy_res     = (n_cmd != CMD_IDLE);
        o_res.done_res     = done;
        o_res.rx_byte      = n_rx;
        o_res.ack_received = n_ack;
    end

endmodule

[rtl/core/i2cm_skid.sv]
module i2cm_skid import i2cm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vld,
    output logic o_rdy,
    input  t_res i_res,
    i2cm_res_if.source o_res
);

    logic r_out_vld;
    logic r_skid_vld;
    t_res r_out;
    t_res r_skid;
    logic out_free;

    assign out_free = ~r_out_vld | o_res.ready;
    assign o_rdy    = ~r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (out_free) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= i_vld;
            end
        end else if (i_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_vld) begin
                r_out <= r_skid;
            end else if (i_vld) begin
                r_out <= i_res;
            end
        end else if (i_vld) begin
            r_skid <= i_res;
        end
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.scl_drive    = r_out.scl_drive;
    assign o_res.sda_drive    = r_out.sda_drive;
    assign o_res.busy_res     = r_out.busy_res;
    assign o_res.done_res     = r_out.done_res;
    assign o_res.rx_byte      = r_out.rx_byte;
    assign o_res.ack_received = r_out.ack_received;

endmodule

[rtl/core/i2c_master_byte_engine.sv]
// I2C master byte engine, advanced by one tick word on i_cmd.
// i_cmd carries a tick: an optional command (START, STOP, write byte,
// read byte, address write/read) and the sampled SDA level. Every accepted
// tick word yields exactly one result word on o_res: the SCL/SDA open-drain
// drive levels, busy, done, the receive byte and the ACK flag.
// Commands are taken only while idle; a command given while busy is dropped.
// The configuration port writes half_period_ticks (index 0, 0 means 10
// ticks) and device_address (index 1); write it only while idle.
// Each result is formed combinationally and held in the output register, or in the skid register while o_res stalls.
// Throughput: one tick word per cycle while i_cmd.ready is high; the step logic between the state
// registers and the result register is single pass.
// When o_res stalls, one more word is caught in the skid register, after
// which i_cmd.ready drops until the output drains.
// Reset (synchronous, active low) returns to idle with both lines released,
// clears the configuration and empties the output stage.
module i2c_master_byte_engine import i2cm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    i2cm_cmd_if.sink              i_cmd,
    i2cm_res_if.source            o_res
);

    logic     acc;
    logic     skid_rdy;
    t_in_word word;
    t_res     step_res;

    assign i_cmd.ready = skid_rdy;
    assign acc         = i_cmd.valid & skid_rdy;

    assign word.operation = i_cmd.operation;
    assign word.tx_byte   = i_cmd.tx_byte;
    assign word.send_ack  = i_cmd.send_ack;
    assign word.sda_in    = i_cmd.sda_in;

    i2cm_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_acc      (acc),
        .i_word     (word),
        .o_res      (step_res)
    );

    i2cm_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (acc),
        .o_rdy   (skid_rdy),
        .i_res   (step_res),
        .o_res   (o_res)
    );

`include "i2c_master_byte_engine_assert.svh"

    `I2CM_ASSERT(a_done_not_busy, i_clk, i_rst_n, o_res.valid |-> !(o_res.done_res && o_res.busy_res), "done and busy together")
    `I2CM_ASSERT(a_stall_means_full, i_clk, i_rst_n, !i_cmd.ready |-> o_res.valid, "input stalled with empty output")
    `I2CM_ASSERT(a_accept_yields_word, i_clk, i_rst_n, acc |=> o_res.valid, "accepted tick produced no result")
    `I2CM_ASSERT_ALWAYS(a_reset_empties, i_clk, $past(!i_rst_n) |-> !o_res.valid, "output valid after reset")

endmodule
